/* rtl/core/valve_motor_stall_controller_defines.svh */
// Assertion macros for the valve motor stall controller.
// Included by the top level; depends on nothing else.
`ifndef VALVE_MOTOR_STALL_CONTROLLER_DEFINES_SVH
`define VALVE_MOTOR_STALL_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VMSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/vmsc_pkg.sv */
// Shared types and constants of the valve motor stall controller.
// Used by every module of the block but vmsc_ram; depends on nothing.
`default_nettype none

package vmsc_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_REF        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_TICKS    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 8'd3;

  // Register reset values.
  localparam logic [6:0]  RST_TICK_THRESHOLD = 7'd64;
  localparam logic [11:0] RST_AMP_REF        = 12'd2048;
  localparam logic [7:0]  RST_STALL_TICKS    = 8'd6;
  localparam logic [7:0]  RST_MAX_ATTEMPTS   = 8'd3;

  // Motor drive codes.
  localparam logic [1:0] DRIVE_OFF   = 2'd0;
  localparam logic [1:0] DRIVE_OPEN  = 2'd1;
  localparam logic [1:0] DRIVE_CLOSE = 2'd2;

  // Valve position codes.
  localparam logic [1:0] POS_UNKNOWN = 2'd0;
  localparam logic [1:0] POS_OPEN    = 2'd1;
  localparam logic [1:0] POS_CLOSED  = 2'd2;
  localparam logic [1:0] POS_FAULT   = 2'd3;

  // Current command codes; the last one is never loaded.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_OPEN  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // Sequencer phase codes.
  localparam logic [1:0] PH_FORWARD  = 2'd0;
  localparam logic [1:0] PH_REVERSE  = 2'd1;
  localparam logic [1:0] PH_BACKOFF  = 2'd2;

  // Request kinds carried in the func field.
  localparam logic FUNC_COMMAND = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // Angle limit and the reciprocal used for the divide by 100.
  localparam logic [7:0]  ANGLE_MAX   = 8'd100;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam int QUEUED_W = 5;

  // One input request.
  typedef struct packed {
    logic        func;
    logic        open_request;
    logic        force_req;
    logic [6:0]  open_angle;
    logic [11:0] current_sample;
  } vmsc_in_t;

  // One result.
  typedef struct packed {
    logic [1:0]          motor_drive;
    logic                busy_res;
    logic [1:0]          valve_position;
    logic [6:0]          last_angle;
    logic [QUEUED_W-1:0] queued;
    logic                dropped;
    logic                position_saved;
  } vmsc_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [6:0]  tick_threshold;
    logic [11:0] amp_ref;
    logic [7:0]  stall_ticks;
    logic [7:0]  max_attempts;
  } vmsc_cfg_t;

  // Queue requests from the sequencer.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] push_data;
  } vmsc_qreq_t;

  // Queue status seen by the sequencer.
  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] head_data;
  } vmsc_qstat_t;

  // Increment that stops at 255.
  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hff) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/vmsc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module vmsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; a read of the address being written
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/vmsc_cfg.sv */
// Configuration registers of the valve motor stall controller.
// Depends on vmsc_pkg.
`default_nettype none

module vmsc_cfg import vmsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output vmsc_cfg_t                  cfg,
  output logic [6:0]                 tick_thr_nxt
);

  vmsc_cfg_t cfg_r;
  vmsc_cfg_t cfg_nxt;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Decode a write request; indexes beyond the list change nothing.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TICK_THRESHOLD: cfg_nxt.tick_threshold = cfg_data[6:0];
        CFG_AMP_REF:        cfg_nxt.amp_ref        = cfg_data[11:0];
        CFG_STALL_TICKS:    cfg_nxt.stall_ticks    = cfg_data[7:0];
        CFG_MAX_ATTEMPTS:   cfg_nxt.max_attempts   = cfg_data[7:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tick_threshold <= RST_TICK_THRESHOLD;
      cfg_r.amp_ref        <= RST_AMP_REF;
      cfg_r.stall_ticks    <= RST_STALL_TICKS;
      cfg_r.max_attempts   <= RST_MAX_ATTEMPTS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg          = cfg_r;
  assign tick_thr_nxt = rst_n ? cfg_nxt.tick_threshold : RST_TICK_THRESHOLD;

endmodule

`default_nettype wire

/* rtl/core/vmsc_queue.sv */
// Command queue: circular buffer in a RAM with head and fill pointers, and a
// bypass so the head entry is ready in the cycle it is needed.
// Depends on vmsc_pkg and vmsc_ram.
`default_nettype none

module vmsc_queue import vmsc_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vmsc_qreq_t          req,
  output vmsc_qstat_t              stat,
  output logic [QUEUED_W-1:0]      queued_nxt
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;

  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  head_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  tail_wrap;
  logic [PTR_W-1:0]  wr_slot;
  logic [7:0]        ram_rd_data;
  logic              byp_vld_r;
  logic [7:0]        byp_data_r;

  // Write slot is head plus fill, wrapped once.
  always_comb begin
    tail_sum  = SUM_W'(head_r) + SUM_W'(fill_r);
    tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_sum - SUM_W'(QUEUE_DEPTH)
                                                  : tail_sum;
    wr_slot   = tail_wrap[PTR_W-1:0];
  end

  // Pointer updates; a push and a pop never come from the same request.
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (req.pop) begin
      head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end else if (req.push) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      fill_r    <= '0;
      byp_vld_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      byp_vld_r <= req.push && (wr_slot == head_nxt);
    end
    byp_data_r <= req.push_data;
  end

  // The RAM is read every cycle at the coming head, so its output always
  // holds the current head entry, except right after a write to that slot.
  vmsc_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.push),
    .wr_addr (wr_slot),
    .wr_data (req.push_data),
    .rd_addr (head_nxt),
    .rd_data (ram_rd_data)
  );

  assign stat.empty     = (fill_r == '0);
  assign stat.full      = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign stat.head_data = byp_vld_r ? byp_data_r : ram_rd_data;
  assign queued_nxt     = QUEUED_W'(fill_nxt);

endmodule

`default_nettype wire

/* rtl/core/vmsc_seq.sv */
// Motor sequencer: command admission, dequeue, stall counting, reversal,
// end-stop detection, timeout and back-off. Produces one result per request.
// Depends on vmsc_pkg.
`default_nettype none

module vmsc_seq import vmsc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire vmsc_in_t            item,
  input  wire vmsc_cfg_t           cfg,
  input  wire logic [6:0]          tick_thr_nxt,
  input  wire vmsc_qstat_t         qstat,
  input  wire logic [QUEUED_W-1:0] queued_nxt,
  output vmsc_qreq_t               qreq,
  output vmsc_out_t                res
);

  logic        active_r, active_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  elapsed_r, elapsed_nxt;
  logic [7:0]  hcr_r, hcr_nxt;
  logic [7:0]  attempt_r, attempt_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [7:0]  angle_tgt_r, angle_tgt_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [6:0]  angle_rec_r, angle_rec_nxt;
  logic [1:0]  drive_r, drive_nxt;
  logic [13:0] prod_r, prod_nxt;

  logic        dropped;
  logic        saved;
  logic        fin_en;
  logic [1:0]  fin_pos;
  logic        take;
  logic        dequeue;
  logic [7:0]  head_angle;
  logic [7:0]  prod_angle;
  logic [6:0]  prod_comp;
  logic [11:0] stall_lvl;
  logic        above_lvl;
  logic        at_lvl;
  logic [7:0]  e1;
  logic [7:0]  h1;
  logic [7:0]  a1;
  logic [7:0]  thr8;
  logic [26:0] backoff_full;
  logic [7:0]  backoff;
  logic [7:0]  backoff_min;

  // Shared terms of the tick sequence.
  always_comb begin
    stall_lvl  = {1'b0, cfg.amp_ref[11:1]};
    above_lvl  = item.current_sample > stall_lvl;
    at_lvl     = item.current_sample >= stall_lvl;
    thr8       = {1'b0, cfg.tick_threshold};
    e1         = sat_inc8(elapsed_r);
    h1         = sat_inc8(hcr_r);
    a1         = sat_inc8(attempt_r);
    head_angle = (qstat.head_data[6:0] > ANGLE_MAX[6:0]) ? ANGLE_MAX
                                                          : {1'b0, qstat.head_data[6:0]};
    take       = item.force_req ||
                 (pos_r != (item.open_request ? POS_OPEN : POS_CLOSED));
    dequeue    = step && (item.func == FUNC_TICK) && !active_r && !qstat.empty;
  end

  // Back-off length from the registered product: divide by 100 through the
  // reciprocal, then limit to the tick threshold.
  always_comb begin
    backoff_full = 27'(prod_r) * 27'(RECIP_100);
    backoff      = backoff_full[RECIP_SHIFT +: 8];
    backoff_min  = (backoff >= thr8) ? thr8 : backoff;
  end

  // Product tick_threshold * (100 - angle) kept current for an open command;
  // it takes the new angle on a dequeue and the new threshold on a write.
  always_comb begin
    prod_angle = dequeue ? head_angle : angle_tgt_r;
    prod_comp  = (prod_angle > ANGLE_MAX) ? 7'd0 : 7'(ANGLE_MAX - prod_angle);
    prod_nxt   = 14'(tick_thr_nxt) * 14'(prod_comp);
  end

  // Next state for one request.
  always_comb begin
    active_nxt    = active_r;
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    hcr_nxt       = hcr_r;
    attempt_nxt   = attempt_r;
    cmd_nxt       = cmd_r;
    angle_tgt_nxt = angle_tgt_r;
    pos_nxt       = pos_r;
    angle_rec_nxt = angle_rec_r;
    drive_nxt     = drive_r;
    dropped       = 1'b0;
    saved         = 1'b0;
    fin_en        = 1'b0;
    fin_pos       = POS_FAULT;
    qreq          = '0;
    qreq.push_data = {item.open_request, item.open_angle};

    if (step) begin
      if (item.func == FUNC_COMMAND) begin
        // Queue the command unless it is unforced and the valve is already there; drop it if full.
        if (take) begin
          if (qstat.full) begin
            dropped = 1'b1;
          end else begin
            qreq.push = 1'b1;
          end
        end
      end else if (!active_r) begin
        // Idle tick: start the next queued command.
        if (!qstat.empty) begin
          qreq.pop   = 1'b1;
          active_nxt = 1'b1;
          if (qstat.head_data[7]) begin
            angle_tgt_nxt = head_angle;
            cmd_nxt       = CMD_OPEN;
            drive_nxt     = DRIVE_OPEN;
          end else begin
            angle_tgt_nxt = '0;
            cmd_nxt       = CMD_CLOSE;
            drive_nxt     = DRIVE_CLOSE;
          end
        end
      end else begin
        // Busy tick.
        elapsed_nxt = e1;
        unique case (phase_r)
          PH_FORWARD: begin
            if (e1 < {2'b00, cfg.tick_threshold[6:1]}) begin
              // Stall window: count high-current ticks.
              if (above_lvl) begin
                hcr_nxt = h1;
                if (h1 >= cfg.stall_ticks) begin
                  hcr_nxt     = '0;
                  attempt_nxt = a1;
                  if (a1 >= cfg.max_attempts || cmd_r == CMD_NONE ||
                      cmd_r == CMD_RSVD) begin
                    fin_en  = 1'b1;
                    fin_pos = POS_FAULT;
                  end else begin
                    drive_nxt   = (cmd_r == CMD_OPEN) ? DRIVE_CLOSE : DRIVE_OPEN;
                    elapsed_nxt = '0;
                    phase_nxt   = PH_REVERSE;
                  end
                end
              end else begin
                hcr_nxt = '0;
              end
            end else if ({1'b0, e1} < {cfg.tick_threshold, 2'b00} >> 1) begin
              // End-stop window.
              hcr_nxt = '0;
              if (above_lvl) begin
                if (cmd_r == CMD_OPEN) begin
                  angle_rec_nxt = angle_tgt_r[6:0];
                  angle_tgt_nxt = backoff_min;
                  cmd_nxt       = CMD_NONE;
                  attempt_nxt   = '0;
                  elapsed_nxt   = '0;
                  phase_nxt     = PH_BACKOFF;
                  drive_nxt     = DRIVE_CLOSE;
                end else if (cmd_r == CMD_CLOSE) begin
                  fin_en  = 1'b1;
                  fin_pos = POS_CLOSED;
                end else begin
                  fin_en  = 1'b1;
                  fin_pos = POS_FAULT;
                end
              end
            end else begin
              // Timeout.
              fin_en  = 1'b1;
              fin_pos = POS_FAULT;
            end
          end
          PH_REVERSE: begin
            if (at_lvl) begin
              drive_nxt   = (cmd_r == CMD_OPEN) ? DRIVE_OPEN : DRIVE_CLOSE;
              hcr_nxt     = '0;
              phase_nxt   = PH_FORWARD;
              elapsed_nxt = '0;
            end else if (e1 > thr8) begin
              fin_en  = 1'b1;
              fin_pos = POS_FAULT;
            end
          end
          PH_BACKOFF: begin
            if (e1 >= angle_tgt_r) begin
              fin_en  = 1'b1;
              fin_pos = POS_OPEN;
            end
          end
          default: begin
            fin_en  = 1'b1;
            fin_pos = POS_FAULT;
          end
        endcase
      end
    end

    // End of an operation: stop the motor and record the position.
    if (fin_en) begin
      drive_nxt     = DRIVE_OFF;
      cmd_nxt       = CMD_NONE;
      angle_tgt_nxt = '0;
      phase_nxt     = PH_FORWARD;
      elapsed_nxt   = '0;
      hcr_nxt       = '0;
      attempt_nxt   = '0;
      active_nxt    = 1'b0;
      pos_nxt       = fin_pos;
      saved         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      phase_r     <= PH_FORWARD;
      elapsed_r   <= '0;
      hcr_r       <= '0;
      attempt_r   <= '0;
      cmd_r       <= CMD_NONE;
      angle_tgt_r <= '0;
      pos_r       <= POS_UNKNOWN;
      angle_rec_r <= '0;
      drive_r     <= DRIVE_OFF;
    end else begin
      active_r    <= active_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      hcr_r       <= hcr_nxt;
      attempt_r   <= attempt_nxt;
      cmd_r       <= cmd_nxt;
      angle_tgt_r <= angle_tgt_nxt;
      pos_r       <= pos_nxt;
      angle_rec_r <= angle_rec_nxt;
      drive_r     <= drive_nxt;
    end
    prod_r <= prod_nxt;
  end

  // Result shows the state after this request.
  always_comb begin
    res.motor_drive    = drive_nxt;
    res.busy_res       = active_nxt;
    res.valve_position = pos_nxt;
    res.last_angle     = angle_rec_nxt;
    res.queued         = queued_nxt;
    res.dropped        = dropped;
    res.position_saved = saved;
  end

endmodule

`default_nettype wire

/* rtl/core/valve_motor_stall_controller.sv */
// Motorized valve controller with a command queue and a stall-aware motor
// sequencer. One request (a command or a tick) is taken per clock cycle, while
// the result register is free or being emptied, and its single result is
// registered: the request lands in an input register, then the sequencer and
// queue update and write the result register. A result held by a stalled
// receiver keeps the next request in the input register until the result is
// taken. The head of the command queue is read ahead from its RAM, with a
// bypass for a just-written entry, so a dequeue never holds up a request. The
// queue RAM is not cleared after reset; only filled entries are ever used.
// Depends on vmsc_pkg, vmsc_cfg, vmsc_queue, vmsc_seq and the defines header.
`default_nettype none

`include "valve_motor_stall_controller_defines.svh"

module valve_motor_stall_controller import vmsc_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire vmsc_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output vmsc_out_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  vmsc_in_t            in_r;
  logic                in_vld_r, in_vld_nxt;
  vmsc_out_t           out_r;
  logic                out_vld_r, out_vld_nxt;
  logic                advance;
  vmsc_cfg_t           cfg;
  logic [6:0]          tick_thr_nxt;
  vmsc_qreq_t          qreq;
  vmsc_qstat_t         qstat;
  logic [QUEUED_W-1:0] queued_nxt;
  vmsc_out_t           res;

  // Pipeline control: a request moves on when the result register is free
  // or is being emptied this cycle.
  always_comb begin
    advance     = in_vld_r && (!out_vld_r || out_ready);
    in_ready    = !in_vld_r || advance;
    in_vld_nxt  = (in_valid && in_ready) || (in_vld_r && !advance);
    out_vld_nxt = advance || (out_vld_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  vmsc_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .tick_thr_nxt (tick_thr_nxt)
  );

  vmsc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (qreq),
    .stat       (qstat),
    .queued_nxt (queued_nxt)
  );

  vmsc_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .item         (in_r),
    .cfg          (cfg),
    .tick_thr_nxt (tick_thr_nxt),
    .qstat        (qstat),
    .queued_nxt   (queued_nxt),
    .qreq         (qreq),
    .res          (res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // The motor only runs while an operation is in progress.
  `VMSC_ASSERT_NOW(a_idle_motor_off, clk, rst_n,
    out_valid && !out_data.busy_res, out_data.motor_drive == DRIVE_OFF,
    "motor driven while no operation is in progress")
  // A position update always ends the operation.
  `VMSC_ASSERT_NOW(a_saved_ends_op, clk, rst_n,
    out_valid && out_data.position_saved, !out_data.busy_res,
    "position saved while the operation is still running")
  // A dropped command implies the queue was full.
  `VMSC_ASSERT_NOW(a_drop_when_full, clk, rst_n,
    out_valid && out_data.dropped, out_data.queued == QUEUED_W'(QUEUE_DEPTH),
    "command dropped while the queue had room")
  // A request that advances yields a result in the next cycle.
  `VMSC_ASSERT_NEXT(a_advance_result, clk, rst_n,
    advance, out_valid,
    "request advanced without producing a result")

endmodule

`default_nettype wire

/* dv/valve_motor_stall_controller_tb.sv */
// Self-checking testbench for the valve motor stall controller: directed and
// random requests, a cycle-free predictor of the sequencer and an in-order scoreboard.
// Depends on vmsc_pkg and the valve_motor_stall_controller top level.
`timescale 1ns / 100ps

module valve_motor_stall_controller_tb;
  import vmsc_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int CLK_PERIOD = 10;

  typedef enum int {RX_FREE, RX_CHOPPY, RX_STARVED} rx_mode_e;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  vmsc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  vmsc_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  valve_motor_stall_controller #(.QUEUE_DEPTH(QDEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predicted register contents.
  logic [6:0]  mdl_tick_thr;
  logic [11:0] mdl_current_thr;
  logic [7:0]  mdl_stall_ticks;
  logic [7:0]  mdl_max_attempts;

  // Predicted queue and sequencer state.
  logic [7:0]  mdl_queue [QDEPTH];
  int          mdl_head;
  int          mdl_fill;
  logic        mdl_active;
  logic [1:0]  mdl_phase;
  logic [7:0]  mdl_elapsed;
  logic [7:0]  mdl_high_run;
  logic [7:0]  mdl_attempts;
  logic [1:0]  mdl_command;
  logic [7:0]  mdl_target;
  logic [1:0]  mdl_position;
  logic [6:0]  mdl_angle_rec;
  logic [1:0]  mdl_drive;
  logic        mdl_saved;

  vmsc_in_t    pending_reqs [$];
  vmsc_out_t   expected_status [$];
  vmsc_out_t   want_status;

  int error_count   = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int items_queued  = 0;
  int opens_done    = 0;
  int closes_done   = 0;
  int faults_done   = 0;
  int drops_seen    = 0;
  int skips_seen    = 0;
  int burst_left    = 1;
  int gap_left      = 0;
  int mode_left     = 0;
  rx_mode_e rx_mode = RX_FREE;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [7:0] bump_sat(input logic [7:0] v);
    return (v == 8'hff) ? v : v + 8'd1;
  endfunction

  function automatic void reset_valve_model();
    mdl_tick_thr     = RST_TICK_THRESHOLD;
    mdl_current_thr  = RST_AMP_REF;
    mdl_stall_ticks  = RST_STALL_TICKS;
    mdl_max_attempts = RST_MAX_ATTEMPTS;
    foreach (mdl_queue[i]) mdl_queue[i] = '0;
    mdl_head      = 0;
    mdl_fill      = 0;
    mdl_active    = 1'b0;
    mdl_phase     = PH_FORWARD;
    mdl_elapsed   = '0;
    mdl_high_run  = '0;
    mdl_attempts  = '0;
    mdl_command   = CMD_NONE;
    mdl_target    = '0;
    mdl_position  = POS_UNKNOWN;
    mdl_angle_rec = '0;
    mdl_drive     = DRIVE_OFF;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_TICK_THRESHOLD: mdl_tick_thr     = value[6:0];
      CFG_AMP_REF:        mdl_current_thr  = value[11:0];
      CFG_STALL_TICKS:    mdl_stall_ticks  = value[7:0];
      CFG_MAX_ATTEMPTS:   mdl_max_attempts = value[7:0];
      default: ;
    endcase
  endfunction

  // End of an operation: motor off, sequencer cleared, position recorded.
  function automatic void settle_valve(input logic [1:0] pos);
    mdl_drive    = DRIVE_OFF;
    mdl_command  = CMD_NONE;
    mdl_target   = '0;
    mdl_phase    = PH_FORWARD;
    mdl_elapsed  = '0;
    mdl_high_run = '0;
    mdl_attempts = '0;
    mdl_active   = 1'b0;
    mdl_position = pos;
    mdl_saved    = 1'b1;
    if (pos == POS_OPEN) opens_done++;
    else if (pos == POS_CLOSED) closes_done++;
    else faults_done++;
  endfunction

  // One tick of a running operation.
  function automatic void advance_motor(input logic [11:0] sample);
    int t;
    int lvl;
    int backoff;
    t   = mdl_tick_thr;
    lvl = mdl_current_thr / 2;
    mdl_elapsed = bump_sat(mdl_elapsed);
    case (mdl_phase)
      PH_FORWARD: begin
        if (mdl_elapsed < t / 2) begin
          // Stall window: a run of high current triggers a reversal or a fault.
          if (sample > lvl) begin
            mdl_high_run = bump_sat(mdl_high_run);
            if (mdl_high_run >= mdl_stall_ticks) begin
              mdl_high_run = '0;
              mdl_attempts = bump_sat(mdl_attempts);
              if (mdl_attempts >= mdl_max_attempts ||
                  (mdl_command != CMD_OPEN && mdl_command != CMD_CLOSE)) begin
                settle_valve(POS_FAULT);
              end else begin
                mdl_drive   = (mdl_command == CMD_OPEN) ? DRIVE_CLOSE : DRIVE_OPEN;
                mdl_elapsed = '0;
                mdl_phase   = PH_REVERSE;
              end
            end
          end else begin
            mdl_high_run = '0;
          end
        end else if (mdl_elapsed < 2 * t) begin
          // End-stop window: high current means the valve reached its stop.
          mdl_high_run = '0;
          if (sample > lvl) begin
            if (mdl_command == CMD_OPEN) begin
              backoff = t * (int'(ANGLE_MAX) - int'(mdl_target)) / int'(ANGLE_MAX);
              mdl_angle_rec = mdl_target[6:0];
              if (backoff >= t) backoff = t;
              mdl_target   = 8'(backoff);
              mdl_command  = CMD_NONE;
              mdl_attempts = '0;
              mdl_elapsed  = '0;
              mdl_phase    = PH_BACKOFF;
              mdl_drive    = DRIVE_CLOSE;
            end else if (mdl_command == CMD_CLOSE) begin
              settle_valve(POS_CLOSED);
            end else begin
              settle_valve(POS_FAULT);
            end
          end
        end else begin
          settle_valve(POS_FAULT);
        end
      end
      PH_REVERSE: begin
        if (sample >= lvl) begin
          mdl_drive    = (mdl_command == CMD_OPEN) ? DRIVE_OPEN : DRIVE_CLOSE;
          mdl_high_run = '0;
          mdl_phase    = PH_FORWARD;
          mdl_elapsed  = '0;
        end else if (mdl_elapsed > t) begin
          settle_valve(POS_FAULT);
        end
      end
      PH_BACKOFF: begin
        if (mdl_elapsed >= mdl_target) settle_valve(POS_OPEN);
      end
      default: settle_valve(POS_FAULT);
    endcase
  endfunction

  // Predicts the result of one request and advances the predicted state.
  function automatic vmsc_out_t valve_next_result(input vmsc_in_t req);
    vmsc_out_t  res;
    logic [7:0] entry;
    logic [1:0] already;
    logic [6:0] raw;
    res       = '0;
    mdl_saved = 1'b0;
    if (req.func == FUNC_COMMAND) begin
      already = req.open_request ? POS_OPEN : POS_CLOSED;
      if (req.force_req || mdl_position != already) begin
        if (mdl_fill >= QDEPTH) begin
          res.dropped = 1'b1;
          drops_seen++;
        end else begin
          mdl_queue[(mdl_head + mdl_fill) % QDEPTH] = {req.open_request, req.open_angle};
          mdl_fill++;
        end
      end else begin
        skips_seen++;
      end
    end else if (!mdl_active) begin
      // Idle tick: start the oldest queued command, if any.
      if (mdl_fill > 0) begin
        entry    = mdl_queue[mdl_head];
        mdl_head = (mdl_head + 1) % QDEPTH;
        mdl_fill--;
        if (entry[7]) begin
          raw         = entry[6:0];
          mdl_target  = (raw > ANGLE_MAX) ? ANGLE_MAX : {1'b0, raw};
          mdl_command = CMD_OPEN;
          mdl_drive   = DRIVE_OPEN;
        end else begin
          mdl_target  = '0;
          mdl_command = CMD_CLOSE;
          mdl_drive   = DRIVE_CLOSE;
        end
        mdl_active = 1'b1;
      end
    end else begin
      advance_motor(req.current_sample);
    end
    res.motor_drive    = mdl_drive;
    res.busy_res       = mdl_active;
    res.valve_position = mdl_position;
    res.last_angle     = mdl_angle_rec;
    res.queued         = QUEUED_W'(mdl_fill);
    res.position_saved = mdl_saved;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Sender: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_status.push_back(valve_next_result(in_data));
        requests_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a mode that is picked anew at random when its countdown runs out.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (rx_mode)
      RX_FREE:    out_ready <= 1'b1;
      RX_CHOPPY:  out_ready <= 1'($urandom);
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Scoreboard: every result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        $error("result with no request waiting: %h", out_data);
        error_count++;
      end else begin
        want_status = expected_status.pop_front();
        check_field("motor_drive", want_status.motor_drive, out_data.motor_drive);
        check_field("busy_res", want_status.busy_res, out_data.busy_res);
        check_field("valve_position", want_status.valve_position, out_data.valve_position);
        check_field("last_angle", want_status.last_angle, out_data.last_angle);
        check_field("queued", want_status.queued, out_data.queued);
        check_field("dropped", want_status.dropped, out_data.dropped);
        check_field("position_saved", want_status.position_saved,
                    out_data.position_saved);
      end
    end
  end

  function automatic void add_command(input logic open_req, input logic force_it,
                                      input logic [6:0] angle);
    vmsc_in_t req;
    req.func           = FUNC_COMMAND;
    req.open_request   = open_req;
    req.force_req      = force_it;
    req.open_angle     = angle;
    req.current_sample = 12'($urandom);
    pending_reqs.push_back(req);
    items_queued++;
  endfunction

  function automatic void add_tick(input logic [11:0] sample);
    vmsc_in_t req;
    req.func           = FUNC_TICK;
    req.open_request   = 1'($urandom);
    req.force_req      = 1'($urandom);
    req.open_angle     = 7'($urandom);
    req.current_sample = sample;
    pending_reqs.push_back(req);
    items_queued++;
  endfunction

  // Current samples relative to the stall level of the present setting.
  function automatic logic [11:0] above_level();
    return 12'($urandom_range(4095, mdl_current_thr / 2 + 1));
  endfunction

  function automatic logic [11:0] below_level();
    int lvl;
    lvl = mdl_current_thr / 2;
    return (lvl == 0) ? 12'd0 : 12'($urandom_range(lvl - 1, 0));
  endfunction

  function automatic logic [6:0] random_angle();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(101, 127));
    return 7'($urandom_range(0, 100));
  endfunction

  // One valve operation: a command and a tick stream shaped to reach a chosen
  // part of the sequence, or a burst of commands as noise.
  task automatic queue_valve_scenario();
    int t;
    int style;
    int n;
    t     = (mdl_tick_thr == 0) ? 1 : mdl_tick_thr;
    style = $urandom_range(0, 9);
    if (style == 9) begin
      n = $urandom_range(1, 18);
      repeat (n) add_command(1'($urandom), 1'($urandom), 7'($urandom));
      return;
    end
    add_command(1'($urandom), ($urandom_range(0, 3) == 0), random_angle());
    add_tick(12'($urandom));
    case (style)
      4, 5: begin
        // Stall, then a reversal that sees current again.
        repeat ($urandom_range(1, 3)) begin
          n = mdl_stall_ticks + $urandom_range(0, 1);
          if (n > t) n = t;
          repeat (n) add_tick(above_level());
          repeat ($urandom_range(0, 3)) add_tick(below_level());
          add_tick($urandom_range(0, 1) ? 12'(mdl_current_thr / 2) : above_level());
        end
      end
      6: repeat (2 * t + 2) add_tick(below_level());
      7: repeat ($urandom_range(1, 2 * t + 4)) add_tick(12'($urandom));
      8: begin
        // Stall, then a reversal that never sees current.
        n = mdl_stall_ticks;
        if (n > t) n = t;
        repeat (n) add_tick(above_level());
        repeat (t + 3) add_tick(below_level());
      end
      default: ;
    endcase
    if (style <= 5) begin
      // Reach the end stop inside its window, then cover the back-off.
      repeat (t / 2 + $urandom_range(0, t)) add_tick(below_level());
      add_tick(above_level());
      repeat ($urandom_range(0, t + 2)) add_tick(below_level());
    end
  endtask

  // Waits until every request is answered and the pipeline is empty.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_status.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, value);
  endtask

  task automatic run_setting(input logic [6:0] tick_thr, input logic [11:0] cur_thr,
                             input logic [7:0] stall, input logic [7:0] attempts,
                             input int count);
    wait_drained();
    write_register(CFG_TICK_THRESHOLD, 12'(tick_thr));
    write_register(CFG_AMP_REF, cur_thr);
    write_register(CFG_STALL_TICKS, 12'(stall));
    write_register(CFG_MAX_ATTEMPTS, 12'(attempts));
    settings_used++;
    items_queued = 0;
    while (items_queued < count) queue_valve_scenario();
  endtask

  // Main sequence: reset, directed requests, then fixed and random settings.
  initial begin
    reset_valve_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    // Overfill the queue with edge-case commands, then tick at extreme currents and around the stall level.
    add_command(1'b0, 1'b0, 7'd0);
    add_command(1'b1, 1'b1, 7'd127);
    add_command(1'b1, 1'b0, 7'd0);
    add_command(1'b1, 1'b0, 7'd100);
    add_command(1'b1, 1'b0, 7'd101);
    add_command(1'b0, 1'b1, 7'd85);
    for (int i = 0; i < 12; i++) add_command(i[0], i[1], 7'(i * 10));
    add_tick(12'hfff);
    add_tick(12'h000);
    add_tick(12'd1024);
    add_tick(12'd1025);
    add_tick(12'd1023);

    run_setting(7'd4, 12'd2000, 8'd2, 8'd2, 200);
    run_setting(7'd1, 12'd0, 8'd1, 8'd1, 120);
    run_setting(7'd127, 12'd4095, 8'd255, 8'd255, 200);
    run_setting(7'd0, 12'($urandom), 8'd0, 8'd0, 60);
    repeat (4) begin
      run_setting(7'($urandom_range(2, 12)), 12'($urandom), 8'($urandom_range(1, 4)),
                  8'($urandom_range(1, 4)), 150);
    end
    run_setting(7'd10, 12'd3000, 8'd3, 8'd3, 150);
    wait_drained();

    $display("Run covered %0d requests and %0d results under %0d register settings.",
             requests_sent, results_seen, settings_used);
    $display("Operations ended open %0d, closed %0d, fault %0d; %0d dropped, %0d skipped.",
             opens_done, closes_done, faults_done, drops_seen, skips_seen);
    if (error_count == 0) begin
      $display("valve_motor_stall_controller verification clean");
    end else begin
      $display("valve_motor_stall_controller verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(3_000_000);
    $display("valve_motor_stall_controller verification failed");
    $finish;
  end

endmodule
